// ===== design/lwbc_pkg.sv =====
// Package for the block cache tag engine: widths, parameter defaults and codes.
// No dependencies; every other design file imports it.
`default_nettype none

package lwbc_pkg;

  localparam int unsigned SLOT_COUNT_DEF     = 16;
  localparam int unsigned BUCKET_ID_BITS_DEF = 16;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACCESS = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BLOCK = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== design/lwbc_if.sv =====
// Item channels of the block cache tag engine: command in, result out.
// Depends on lwbc_pkg for widths.
`default_nettype none

interface lwbc_cmd_if #(
  parameter int unsigned BUCKET_ID_BITS = lwbc_pkg::BUCKET_ID_BITS_DEF
);
  import lwbc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [BUCKET_ID_BITS-1:0] bkt_id;

  modport source (output valid, command, bkt_id, input ready);
  modport sink   (input valid, command, bkt_id, output ready);
endinterface

interface lwbc_res_if;
  import lwbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  hit;
  logic                  fetch_valid;
  logic [ADDR_W-1:0]     fetch_block;
  logic                  writeback_valid;
  logic [ADDR_W-1:0]     writeback_block;
  logic                  last;

  modport source (output valid, slot, hit, fetch_valid, fetch_block, writeback_valid,
                  writeback_block, last, input ready);
  modport sink   (input valid, slot, hit, fetch_valid, fetch_block, writeback_valid,
                  writeback_block, last, output ready);
endinterface

`default_nettype wire

// ===== design/lru_writeback_block_cache_tags.sv =====
// Top level of the block cache tag engine: sequencer, slot memory and remainder unit.
// Depends on lwbc_pkg, lwbc_if, lwbc_tag_mem and lwbc_mod_unit.
//
// Usage: commands arrive on cmd_i (valid/ready): access a bucket, mark a bucket
// dirty, or flush. Results leave on res_o (valid/ready) through an output
// register. Access and mark give one item with last set; flush gives one item
// per dirty valid slot in slot order, then a closing item with only last set.
// Command code 3 is taken and dropped without a result.
// Configuration (start_block, block_count) is written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write it only while the block is idle, the block itself does not enforce this.
// Sequence: every access or mark reads all SLOT_COUNT slots from the slot memory,
// one per cycle; a miss then runs the bit-serial remainder unit for the fetch
// address, and a dirty victim runs it again for the write-back address. Flush
// reads the slots one at a time and runs the remainder unit once per dirty slot.
// One command is in work at a time; cmd_i.ready is high only when idle, but a
// new command is taken while the previous result still sits in the output
// register. A stalled receiver holds the output item and stalls the sequencer
// only when it next has an item to emit.
// Reset clears all slots (they read as empty and clean), the stamp counter and
// the configuration (start_block 0, block_count 1). No clearing pass is needed.
`default_nettype none

module lru_writeback_block_cache_tags #(
  parameter int unsigned SLOT_COUNT     = lwbc_pkg::SLOT_COUNT_DEF,
  parameter int unsigned BUCKET_ID_BITS = lwbc_pkg::BUCKET_ID_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  lwbc_cmd_if.sink                              cmd_i,
  lwbc_res_if.source                            res_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lwbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lwbc_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import lwbc_pkg::*;

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned ENTRY_W = BUCKET_ID_BITS + STAMP_W + 1;

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SCAN      = 10'b00_0000_0010,
    S_DECIDE    = 10'b00_0000_0100,
    S_MOD_FETCH = 10'b00_0000_1000,
    S_MOD_WB    = 10'b00_0001_0000,
    S_RESULT    = 10'b00_0010_0000,
    S_FL_RD     = 10'b00_0100_0000,
    S_FL_CHK    = 10'b00_1000_0000,
    S_FL_MOD    = 10'b01_0000_0000,
    S_FL_EMIT   = 10'b10_0000_0000
  } state_e;

  // flush closing item reuses S_RESULT with cleared pending fields

  state_e                    state_q, state_d;
  cmd_e                      cmd_q, cmd_d;
  logic [BUCKET_ID_BITS-1:0] id_q, id_d;

  // scan bookkeeping
  logic [IDX_W:0]            next_addr_q, next_addr_d;
  logic                      data_vld_q, data_vld_d;
  logic [IDX_W-1:0]          data_idx_q, data_idx_d;

  logic                      match_found_q, match_found_d;
  logic [IDX_W-1:0]          match_idx_q, match_idx_d;
  logic [STAMP_W-1:0]        match_stamp_q, match_stamp_d;
  logic                      match_dirty_q, match_dirty_d;
  logic                      empty_found_q, empty_found_d;
  logic [IDX_W-1:0]          empty_idx_q, empty_idx_d;
  logic [STAMP_W-1:0]        min_stamp_q, min_stamp_d;
  logic [IDX_W-1:0]          min_idx_q, min_idx_d;
  logic [BUCKET_ID_BITS-1:0] min_tag_q, min_tag_d;
  logic                      min_dirty_q, min_dirty_d;

  logic [STAMP_W-1:0]        stamp_cnt_q, stamp_cnt_d;
  logic [STAMP_W-1:0]        new_stamp;

  logic [IDX_W-1:0]          fl_idx_q, fl_idx_d;
  logic [ENTRY_W-1:0]        fl_entry_q, fl_entry_d;

  // pending result fields
  logic [IDX_W-1:0]          pend_slot_q, pend_slot_d;
  logic                      pend_hit_q, pend_hit_d;
  logic                      pend_fv_q, pend_fv_d;
  logic [ADDR_W-1:0]         pend_fb_q, pend_fb_d;
  logic                      pend_wv_q, pend_wv_d;
  logic [ADDR_W-1:0]         pend_wb_q, pend_wb_d;

  // output register
  logic                      res_vld_q, res_vld_d;
  logic [SLOT_OUT_W-1:0]     res_slot_q, res_slot_d;
  logic                      res_hit_q, res_hit_d;
  logic                      res_fv_q, res_fv_d;
  logic [ADDR_W-1:0]         res_fb_q, res_fb_d;
  logic                      res_wv_q, res_wv_d;
  logic [ADDR_W-1:0]         res_wb_q, res_wb_d;
  logic                      res_last_q, res_last_d;
  logic                      out_free;

  logic [CFG_W-1:0]          start_q, start_d;
  logic [CFG_W-1:0]          count_q, count_d;

  // memory and remainder unit hookup
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic [ENTRY_W-1:0]        rd_data;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [ENTRY_W-1:0]        wr_data;
  logic                      mod_start;
  logic [BUCKET_ID_BITS-1:0] mod_dvd;
  logic                      mod_done;
  logic [ADDR_W-1:0]         mod_rem;
  logic [ADDR_W-1:0]         mod_addr;

  logic                      e_dirty;
  logic [STAMP_W-1:0]        e_stamp;
  logic [BUCKET_ID_BITS-1:0] e_tag;
  logic                      e_valid;
  logic                      last_slot;

  assign e_dirty   = rd_data[0];
  assign e_stamp   = rd_data[STAMP_W:1];
  assign e_tag     = rd_data[ENTRY_W-1 -: BUCKET_ID_BITS];
  assign e_valid   = (e_stamp != '0);
  assign new_stamp = stamp_cnt_q + 1'b1;
  assign mod_addr  = start_q + mod_rem;
  assign out_free  = !res_vld_q || res_o.ready;
  assign last_slot = (fl_idx_q == IDX_W'(SLOT_COUNT - 1));

  lwbc_tag_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .ENTRY_W    (ENTRY_W)
  ) u_tag_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  lwbc_mod_unit #(
    .DIVIDEND_W (BUCKET_ID_BITS)
  ) u_mod_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Configuration writes
  always_comb begin
    start_d = start_q;
    count_d = count_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_BLOCK: start_d = cfg_wdata_i;
        CFG_BLOCK_COUNT: count_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    id_d          = id_q;
    next_addr_d   = next_addr_q;
    data_vld_d    = 1'b0;
    data_idx_d    = data_idx_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    match_stamp_d = match_stamp_q;
    match_dirty_d = match_dirty_q;
    empty_found_d = empty_found_q;
    empty_idx_d   = empty_idx_q;
    min_stamp_d   = min_stamp_q;
    min_idx_d     = min_idx_q;
    min_tag_d     = min_tag_q;
    min_dirty_d   = min_dirty_q;
    stamp_cnt_d   = stamp_cnt_q;
    fl_idx_d      = fl_idx_q;
    fl_entry_d    = fl_entry_q;
    pend_slot_d   = pend_slot_q;
    pend_hit_d    = pend_hit_q;
    pend_fv_d     = pend_fv_q;
    pend_fb_d     = pend_fb_q;
    pend_wv_d     = pend_wv_q;
    pend_wb_d     = pend_wb_q;
    res_vld_d     = res_vld_q && !res_o.ready;
    res_slot_d    = res_slot_q;
    res_hit_d     = res_hit_q;
    res_fv_d      = res_fv_q;
    res_fb_d      = res_fb_q;
    res_wv_d      = res_wv_q;
    res_wb_d      = res_wb_q;
    res_last_d    = res_last_q;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    mod_start     = 1'b0;
    mod_dvd       = id_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d         = cmd_e'(cmd_i.command);
          id_d          = cmd_i.bkt_id;
          match_found_d = 1'b0;
          empty_found_d = 1'b0;
          min_stamp_d   = '1;
          min_idx_d     = '0;
          case (cmd_e'(cmd_i.command))
            CMD_ACCESS, CMD_MARK: begin
              // start the slot sweep at slot zero
              rd_en       = 1'b1;
              rd_addr     = '0;
              data_vld_d  = 1'b1;
              data_idx_d  = '0;
              next_addr_d = (IDX_W+1)'(1);
              state_d     = S_SCAN;
            end
            CMD_FLUSH: begin
              fl_idx_d = '0;
              state_d  = S_FL_RD;
            end
            default: ;  // unused code: drop the item
          endcase
        end
      end

      S_SCAN: begin
        if (next_addr_q < (IDX_W+1)'(SLOT_COUNT)) begin
          rd_en       = 1'b1;
          rd_addr     = next_addr_q[IDX_W-1:0];
          data_vld_d  = 1'b1;
          data_idx_d  = next_addr_q[IDX_W-1:0];
          next_addr_d = next_addr_q + 1'b1;
        end
        if (data_vld_q) begin
          if (e_valid && (e_tag == id_q) && !match_found_q) begin
            match_found_d = 1'b1;
            match_idx_d   = data_idx_q;
            match_stamp_d = e_stamp;
            match_dirty_d = e_dirty;
          end
          if (!e_valid && !empty_found_q) begin
            empty_found_d = 1'b1;
            empty_idx_d   = data_idx_q;
          end
          // oldest valid slot, first on ties; slot zero seeds the search
          if (e_valid && ((e_stamp < min_stamp_q) || (data_idx_q == '0))) begin
            min_stamp_d = e_stamp;
            min_idx_d   = data_idx_q;
            min_tag_d   = e_tag;
            min_dirty_d = e_dirty;
          end
          if (data_idx_q == IDX_W'(SLOT_COUNT - 1)) begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        pend_hit_d = 1'b0;
        pend_fv_d  = 1'b0;
        pend_fb_d  = '0;
        pend_wv_d  = 1'b0;
        pend_wb_d  = '0;
        pend_slot_d = '0;
        state_d    = S_RESULT;
        if (cmd_q == CMD_ACCESS) begin
          stamp_cnt_d = new_stamp;
          wr_en       = 1'b1;
          if (match_found_q) begin
            // hit: restamp, keep tag and dirty bit
            wr_addr     = match_idx_q;
            wr_data     = {id_q, new_stamp, match_dirty_q};
            pend_slot_d = match_idx_q;
            pend_hit_d  = 1'b1;
          end else begin
            // miss: fill the victim clean, then work out the addresses
            wr_addr     = empty_found_q ? empty_idx_q : min_idx_q;
            wr_data     = {id_q, new_stamp, 1'b0};
            pend_slot_d = empty_found_q ? empty_idx_q : min_idx_q;
            pend_fv_d   = 1'b1;
            pend_wv_d   = !empty_found_q && min_dirty_q;
            mod_start   = 1'b1;
            mod_dvd     = id_q;
            state_d     = S_MOD_FETCH;
          end
        end else if (match_found_q) begin
          wr_en       = 1'b1;
          wr_addr     = match_idx_q;
          wr_data     = {id_q, match_stamp_q, 1'b1};
          pend_slot_d = match_idx_q;
          pend_hit_d  = 1'b1;
        end
      end

      S_MOD_FETCH: begin
        if (mod_done) begin
          pend_fb_d = mod_addr;
          if (pend_wv_q) begin
            mod_start = 1'b1;
            mod_dvd   = min_tag_q;
            state_d   = S_MOD_WB;
          end else begin
            state_d = S_RESULT;
          end
        end
      end

      S_MOD_WB: begin
        if (mod_done) begin
          pend_wb_d = mod_addr;
          state_d   = S_RESULT;
        end
      end

      S_RESULT: begin
        if (out_free) begin
          res_vld_d  = 1'b1;
          res_slot_d = SLOT_OUT_W'(pend_slot_q);
          res_hit_d  = pend_hit_q;
          res_fv_d   = pend_fv_q;
          res_fb_d   = pend_fb_q;
          res_wv_d   = pend_wv_q;
          res_wb_d   = pend_wb_q;
          res_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_FL_RD: begin
        rd_en   = 1'b1;
        rd_addr = fl_idx_q;
        state_d = S_FL_CHK;
      end

      S_FL_CHK: begin
        fl_entry_d = rd_data;
        if (e_dirty && e_valid) begin
          mod_start = 1'b1;
          mod_dvd   = e_tag;
          state_d   = S_FL_MOD;
        end else if (last_slot) begin
          // closing item: every field clear except last
          pend_slot_d = '0;
          pend_hit_d  = 1'b0;
          pend_fv_d   = 1'b0;
          pend_fb_d   = '0;
          pend_wv_d   = 1'b0;
          pend_wb_d   = '0;
          state_d     = S_RESULT;
        end else begin
          fl_idx_d = fl_idx_q + 1'b1;
          state_d  = S_FL_RD;
        end
      end

      S_FL_MOD: begin
        if (mod_done) begin
          pend_wb_d = mod_addr;
          state_d   = S_FL_EMIT;
        end
      end

      S_FL_EMIT: begin
        if (out_free) begin
          res_vld_d  = 1'b1;
          res_slot_d = SLOT_OUT_W'(fl_idx_q);
          res_hit_d  = 1'b0;
          res_fv_d   = 1'b0;
          res_fb_d   = '0;
          res_wv_d   = 1'b1;
          res_wb_d   = pend_wb_q;
          res_last_d = 1'b0;
          // clean the slot once its write-back is out
          wr_en      = 1'b1;
          wr_addr    = fl_idx_q;
          wr_data    = {fl_entry_q[ENTRY_W-1:1], 1'b0};
          if (last_slot) begin
            pend_slot_d = '0;
            pend_hit_d  = 1'b0;
            pend_fv_d   = 1'b0;
            pend_fb_d   = '0;
            pend_wv_d   = 1'b0;
            pend_wb_d   = '0;
            state_d     = S_RESULT;
          end else begin
            fl_idx_d = fl_idx_q + 1'b1;
            state_d  = S_FL_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      next_addr_q   <= '0;
      data_vld_q    <= 1'b0;
      match_found_q <= 1'b0;
      empty_found_q <= 1'b0;
      stamp_cnt_q   <= '0;
      fl_idx_q      <= '0;
      res_vld_q     <= 1'b0;
      start_q       <= '0;
      count_q       <= CFG_W'(1);
    end else begin
      state_q       <= state_d;
      next_addr_q   <= next_addr_d;
      data_vld_q    <= data_vld_d;
      match_found_q <= match_found_d;
      empty_found_q <= empty_found_d;
      stamp_cnt_q   <= stamp_cnt_d;
      fl_idx_q      <= fl_idx_d;
      res_vld_q     <= res_vld_d;
      start_q       <= start_d;
      count_q       <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    id_q          <= id_d;
    data_idx_q    <= data_idx_d;
    match_idx_q   <= match_idx_d;
    match_stamp_q <= match_stamp_d;
    match_dirty_q <= match_dirty_d;
    empty_idx_q   <= empty_idx_d;
    min_stamp_q   <= min_stamp_d;
    min_idx_q     <= min_idx_d;
    min_tag_q     <= min_tag_d;
    min_dirty_q   <= min_dirty_d;
    fl_entry_q    <= fl_entry_d;
    pend_slot_q   <= pend_slot_d;
    pend_hit_q    <= pend_hit_d;
    pend_fv_q     <= pend_fv_d;
    pend_fb_q     <= pend_fb_d;
    pend_wv_q     <= pend_wv_d;
    pend_wb_q     <= pend_wb_d;
    res_slot_q    <= res_slot_d;
    res_hit_q     <= res_hit_d;
    res_fv_q      <= res_fv_d;
    res_fb_q      <= res_fb_d;
    res_wv_q      <= res_wv_d;
    res_wb_q      <= res_wb_d;
    res_last_q    <= res_last_d;
  end

  // Ports
  assign cmd_i.ready           = (state_q == S_IDLE);
  assign res_o.valid           = res_vld_q;
  assign res_o.slot            = res_slot_q;
  assign res_o.hit             = res_hit_q;
  assign res_o.fetch_valid     = res_fv_q;
  assign res_o.fetch_block     = res_fb_q;
  assign res_o.writeback_valid = res_wv_q;
  assign res_o.writeback_block = res_wb_q;
  assign res_o.last            = res_last_q;

endmodule

`default_nettype wire

// ===== design/lwbc_tag_mem.sv =====
// Slot memory: one synchronous read port, one write port; read data is registered.
// Per-entry written flags make never-written entries read as zero. Uses lwbc_pkg.
`default_nettype none

module lwbc_tag_mem #(
  parameter int unsigned SLOT_COUNT = lwbc_pkg::SLOT_COUNT_DEF,
  parameter int unsigned ENTRY_W    = 49
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] rd_addr_i,
  output logic      [ENTRY_W-1:0]            rd_data_o,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] wr_addr_i,
  input  wire logic [ENTRY_W-1:0]            wr_data_i
);
  import lwbc_pkg::*;

  logic [ENTRY_W-1:0]    mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written_q;
  logic [ENTRY_W-1:0]    rd_data_q;
  logic                  rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== design/lwbc_mod_unit.sv =====
// Iterative remainder unit: one dividend bit per cycle, done pulse at the end.
// A zero divisor gives a zero remainder. Uses lwbc_pkg.
`default_nettype none

module lwbc_mod_unit #(
  parameter int unsigned DIVIDEND_W = lwbc_pkg::BUCKET_ID_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [lwbc_pkg::ADDR_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [lwbc_pkg::ADDR_W-1:0] rem_o
);
  import lwbc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [ADDR_W-1:0]     rem_q, rem_d;
  logic [ADDR_W:0]       trial;

  always_comb begin
    trial  = {rem_q, dvd_q[DIVIDEND_W-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // restoring step: shift in the next bit, subtract when it fits
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = ADDR_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[ADDR_W-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = (divisor_i == '0) ? '0 : rem_q;

endmodule

`default_nettype wire

// ===== design/lwbc_checker.sv =====
// Port-level checks for the block cache tag engine, bound to its top level.
// Depends on lwbc_pkg and lru_writeback_block_cache_tags.
`default_nettype none

module lwbc_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              res_valid,
  input wire logic                              res_ready,
  input wire logic [lwbc_pkg::SLOT_OUT_W-1:0]   res_slot,
  input wire logic                              res_hit,
  input wire logic                              res_fetch_valid,
  input wire logic [lwbc_pkg::ADDR_W-1:0]       res_fetch_block,
  input wire logic                              res_writeback_valid,
  input wire logic [lwbc_pkg::ADDR_W-1:0]       res_writeback_block,
  input wire logic                              res_last
);
  import lwbc_pkg::*;

  // hold a stalled item
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_slot) && $stable(res_hit) &&
      $stable(res_fetch_valid) && $stable(res_fetch_block) &&
      $stable(res_writeback_valid) && $stable(res_writeback_block) && $stable(res_last))
    else $error("stalled result item changed");

  // a hit item never carries a fetch or a write-back, and is always last
  a_hit_no_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_hit |-> !res_fetch_valid && !res_writeback_valid && res_last)
    else $error("hit item carries a transfer");

  a_flush_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_writeback_valid && !res_fetch_valid |-> !res_last && !res_hit)
    else $error("flush write-back item flagged last or hit");

  a_fetch_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_fetch_valid |-> res_last && !res_hit)
    else $error("fetch item malformed");

endmodule

bind lru_writeback_block_cache_tags lwbc_checker u_lwbc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .res_valid           (res_o.valid),
  .res_ready           (res_o.ready),
  .res_slot            (res_o.slot),
  .res_hit             (res_o.hit),
  .res_fetch_valid     (res_o.fetch_valid),
  .res_fetch_block     (res_o.fetch_block),
  .res_writeback_valid (res_o.writeback_valid),
  .res_writeback_block (res_o.writeback_block),
  .res_last            (res_o.last)
);

`default_nettype wire
